FILE: rtl/core/assert_macros.svh
// assertion macros for the checker file of the decal pool
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication with a reset qualifier
`define DPAF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication with a reset qualifier
`define DPAF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: rtl/core/dpaf_pkg.sv
// shared types and constants of the decal pool with age fade
// no dependencies; compiled first
`default_nettype none

package dpaf_pkg;

   localparam int POOL_DEPTH = 64;
   localparam int MAX_VERTS  = 10;

   localparam int STAMP_W = 32;
   localparam int COLOR_W = 8;
   localparam int VERTS_W = 4;
   localparam int SHADER_W = 16;

   localparam int LIFE_MS       = 10000;
   localparam int FADE_MS       = 1000;
   localparam int FADE_START_MS = LIFE_MS - FADE_MS;
   localparam int COLOR_MAX     = 255;

   // remaining-time width inside the fade window
   localparam int T_W = $clog2(FADE_MS);
   localparam logic [T_W-1:0] T_OFFSET = T_W'(LIFE_MS % (2 ** T_W));

   // exact floor(p / FADE_MS) for p below 2^PROD_W
   localparam int PROD_W    = COLOR_W + T_W;
   localparam int DIV_SHIFT = PROD_W + T_W;
   localparam int DIV_RECIP = ((2 ** DIV_SHIFT) + FADE_MS - 1) / FADE_MS;
   localparam int RECIP_W   = $clog2(DIV_RECIP + 1);

   localparam logic CMD_ALLOC  = 1'b0;
   localparam logic CMD_RENDER = 1'b1;

   typedef struct packed {
      logic [STAMP_W-1:0]  stamp;
      logic [SHADER_W-1:0] shader;
      logic [COLOR_W-1:0]  red;
      logic [COLOR_W-1:0]  green;
      logic [COLOR_W-1:0]  blue;
      logic [COLOR_W-1:0]  alpha;
      logic                fade_alpha_only;
      logic [VERTS_W-1:0]  verts;
   } entry_type;

   typedef struct packed {
      logic [SHADER_W-1:0] shader;
      logic [VERTS_W-1:0]  verts;
      logic [COLOR_W-1:0]  red;
      logic [COLOR_W-1:0]  green;
      logic [COLOR_W-1:0]  blue;
      logic [COLOR_W-1:0]  alpha;
      logic                last;
   } result_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT,
      CELL_FROM_HEAD
   } cell_op_type;

   typedef struct packed {
      logic advance;
      logic valid;
      logic last;
   } fade_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/core/dpaf_if.sv
// valid/ready channel interfaces: request, response and csr write
// depends on dpaf_pkg
`default_nettype none

interface dpaf_req_if;
   import dpaf_pkg::*;
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [STAMP_W-1:0]  now_ms;
   logic [SHADER_W-1:0] shader_handle;
   logic [VERTS_W-1:0]  vert_count;
   logic [COLOR_W-1:0]  red;
   logic [COLOR_W-1:0]  green;
   logic [COLOR_W-1:0]  blue;
   logic [COLOR_W-1:0]  alpha;
   logic                fade_alpha_only;

   modport source (output valid, cmd, now_ms, shader_handle, vert_count, red, green, blue,
                   alpha, fade_alpha_only, input ready);
   modport sink (input valid, cmd, now_ms, shader_handle, vert_count, red, green, blue,
                 alpha, fade_alpha_only, output ready);
endinterface

interface dpaf_rsp_if;
   import dpaf_pkg::*;
   logic                valid;
   logic                ready;
   logic [SHADER_W-1:0] out_shader;
   logic [VERTS_W-1:0]  out_verts;
   logic [COLOR_W-1:0]  mod_red;
   logic [COLOR_W-1:0]  mod_green;
   logic [COLOR_W-1:0]  mod_blue;
   logic [COLOR_W-1:0]  mod_alpha;
   logic                last;

   modport source (output valid, out_shader, out_verts, mod_red, mod_green, mod_blue,
                   mod_alpha, last, input ready);
   modport sink (input valid, out_shader, out_verts, mod_red, mod_green, mod_blue,
                 mod_alpha, last, output ready);
endinterface

interface dpaf_csr_if;
   logic valid;
   logic ready;
   logic marks_enable;

   modport source (output valid, marks_enable, input ready);
   modport sink (input valid, marks_enable, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/decal_pool_age_fade.sv
// decal pool with age fade: a chain of entry cells, newest at cell 0, plus a fade pipeline
// allocate on a full pool first evicts the run of entries that share the oldest stamp
// render: live entries pass one by one through the cell chain head into the fade pipeline
// throughput: one entry per cycle at the chain head unless stalled, one result per cycle at most
// reset: synchronous active high, pool empty, marks enabled; cell contents are not cleared
// depends on dpaf_pkg, dpaf_if, dpaf_cell and dpaf_fade
`default_nettype none

module decal_pool_age_fade #(
   parameter int PoolDepth = dpaf_pkg::POOL_DEPTH,
   parameter int MaxVerts  = dpaf_pkg::MAX_VERTS
) (
   input  logic        clock,
   input  logic        reset,
   dpaf_req_if.sink    req_bus,
   dpaf_rsp_if.source  rsp_bus,
   dpaf_csr_if.sink    csr_bus
);
   import dpaf_pkg::*;

   localparam int CNT_W = $clog2(PoolDepth + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVICT,
      ST_RENDER
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       count_ff;      // live entries, cells 0..count-1
   logic                   enable_ff;     // marks_enable register
   logic [CNT_W-1:0]       remain_ff;     // entries not yet walked in this pass
   logic [CNT_W-1:0]       kept_ff;       // survivors parked behind the unwalked ones
   logic [PoolDepth-1:0]   survive_ff;    // survive flags aligned with the cells
   logic [PoolDepth-1:0]   match_ff;      // oldest-stamp flags aligned with the cells
   logic [STAMP_W-1:0]     now_ff;
   entry_type              pend_ff;       // allocate waiting for the eviction to finish

   entry_type              cell_entry [PoolDepth];
   cell_op_type            cell_op    [PoolDepth];
   logic [PoolDepth-1:0]   cell_alive;
   logic [PoolDepth-1:0]   cell_match;
   logic [PoolDepth-1:0]   live_mask;

   entry_type              req_entry;
   entry_type              new_entry;
   logic                   req_fire;
   logic                   accept_alloc;
   logic                   accept_render;
   logic                   full;
   logic                   evict_more;
   logic                   do_insert;
   logic                   do_step;
   logic                   head_last;
   logic [CNT_W-1:0]       wr_pos;

   fade_ctl_type           fade_ctl;
   logic                   fade_busy;
   logic                   out_valid;
   result_type             out_result;
   logic                   advance;

   // incoming mark, vertex count saturated
   always_comb begin
      req_entry.stamp           = req_bus.now_ms;
      req_entry.shader          = req_bus.shader_handle;
      req_entry.red             = req_bus.red;
      req_entry.green           = req_bus.green;
      req_entry.blue            = req_bus.blue;
      req_entry.alpha           = req_bus.alpha;
      req_entry.fade_alpha_only = req_bus.fade_alpha_only;
      req_entry.verts           = (req_bus.vert_count > VERTS_W'(MaxVerts))
                                  ? VERTS_W'(MaxVerts) : req_bus.vert_count;
   end

   assign new_entry = (state_ff == ST_IDLE) ? req_entry : pend_ff;

   // handshakes: requests only when idle and the fade pipe holds nothing in flight
   assign req_bus.ready = (state_ff == ST_IDLE) && !fade_busy;
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign accept_alloc  = req_fire && enable_ff && (req_bus.cmd == CMD_ALLOC);
   assign accept_render = req_fire && enable_ff && (req_bus.cmd == CMD_RENDER);
   assign full          = count_ff == CNT_W'(PoolDepth);

   // the whole render path stalls while the response register is held
   assign advance = !out_valid || rsp_bus.ready;

   // eviction walks the oldest end, one entry a cycle, while the stamp matches
   assign evict_more = (count_ff != '0) && match_ff[PoolDepth-1];
   assign do_insert  = (accept_alloc && !full) || ((state_ff == ST_EVICT) && !evict_more);
   assign do_step    = (state_ff == ST_RENDER) && (remain_ff != '0) && advance;

   // a survivor lands right behind the survivors already parked
   assign wr_pos    = remain_ff - CNT_W'(1) + kept_ff;
   assign head_last = survive_ff[0] && !(|survive_ff[PoolDepth-1:1]);

   always_comb begin
      for (int i = 0; i < PoolDepth; i++) begin
         live_mask[i] = CNT_W'(i) < count_ff;
         priority if (do_insert) begin
            cell_op[i] = CELL_FROM_PREV;
         end else if (do_step) begin
            cell_op[i] = (survive_ff[0] && (CNT_W'(i) == wr_pos)) ? CELL_FROM_HEAD
                                                                  : CELL_FROM_NEXT;
         end else begin
            cell_op[i] = CELL_HOLD;
         end
      end
   end

   // cell chain: cell 0 newest, shifts up on insert and down while rendering
   for (genvar i = 0; i < PoolDepth; i++) begin : g_cell
      entry_type prev_entry;
      entry_type next_entry;

      if (i == 0) begin : g_first
         assign prev_entry = new_entry;
      end else begin : g_prev
         assign prev_entry = cell_entry[i-1];
      end

      if (i == PoolDepth - 1) begin : g_end
         assign next_entry = cell_entry[0];
      end else begin : g_next
         assign next_entry = cell_entry[i+1];
      end

      dpaf_cell u_cell (
         .clock      (clock),
         .op         (cell_op[i]),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .head_entry (cell_entry[0]),
         .now_ms     (req_bus.now_ms),
         .ref_stamp  (cell_entry[PoolDepth-1].stamp),
         .entry      (cell_entry[i]),
         .alive      (cell_alive[i]),
         .match      (cell_match[i])
      );
   end

   // control state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         enable_ff <= 1'b1;
         remain_ff <= '0;
         kept_ff   <= '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            enable_ff <= csr_bus.marks_enable;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept_alloc) begin
                  if (full) begin
                     // full pool: oldest entry sits at the last cell
                     pend_ff  <= req_entry;
                     match_ff <= cell_match;
                     state_ff <= ST_EVICT;
                  end else begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
               end else if (accept_render) begin
                  now_ff     <= req_bus.now_ms;
                  survive_ff <= cell_alive & live_mask;
                  remain_ff  <= count_ff;
                  kept_ff    <= '0;
                  state_ff   <= ST_RENDER;
               end
            end
            ST_EVICT: begin
               if (evict_more) begin
                  count_ff <= count_ff - CNT_W'(1);
                  match_ff <= match_ff << 1;
               end else begin
                  count_ff <= count_ff + CNT_W'(1);
                  state_ff <= ST_IDLE;
               end
            end
            ST_RENDER: begin
               if (remain_ff == '0) begin
                  count_ff <= kept_ff;
                  state_ff <= ST_IDLE;
               end else if (advance) begin
                  remain_ff  <= remain_ff - CNT_W'(1);
                  kept_ff    <= kept_ff + CNT_W'(survive_ff[0]);
                  survive_ff <= survive_ff >> 1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // chain head feeds the fade pipeline, bubbles for expired entries
   assign fade_ctl.advance = advance;
   assign fade_ctl.valid   = do_step && survive_ff[0];
   assign fade_ctl.last    = head_last;

   dpaf_fade u_fade (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fade_ctl),
      .head      (cell_entry[0]),
      .now_ms    (now_ff),
      .busy      (fade_busy),
      .out_valid (out_valid),
      .result    (out_result)
   );

   // response channel straight from the output register
   assign rsp_bus.valid      = out_valid;
   assign rsp_bus.out_shader = out_result.shader;
   assign rsp_bus.out_verts  = out_result.verts;
   assign rsp_bus.mod_red    = out_result.red;
   assign rsp_bus.mod_green  = out_result.green;
   assign rsp_bus.mod_blue   = out_result.blue;
   assign rsp_bus.mod_alpha  = out_result.alpha;
   assign rsp_bus.last       = out_result.last;

endmodule

`default_nettype wire

FILE: rtl/core/dpaf_cell.sv
// one pool cell: holds a decal entry, loads from a neighbor or the head
// depends on dpaf_pkg
`default_nettype none

module dpaf_cell (
   input  logic                          clock,
   input  dpaf_pkg::cell_op_type         op,
   input  dpaf_pkg::entry_type           prev_entry,
   input  dpaf_pkg::entry_type           next_entry,
   input  dpaf_pkg::entry_type           head_entry,
   input  logic [dpaf_pkg::STAMP_W-1:0]  now_ms,
   input  logic [dpaf_pkg::STAMP_W-1:0]  ref_stamp,
   output dpaf_pkg::entry_type           entry,
   output logic                          alive,
   output logic                          match
);
   import dpaf_pkg::*;

   entry_type          entry_ff;
   logic [STAMP_W:0]   deadline;

   always_ff @(posedge clock) begin
      unique case (op)
         CELL_HOLD:      entry_ff <= entry_ff;
         CELL_FROM_PREV: entry_ff <= prev_entry;
         CELL_FROM_NEXT: entry_ff <= next_entry;
         CELL_FROM_HEAD: entry_ff <= head_entry;
      endcase
   end

   // deadline without wrap, alive while now has not passed it
   assign deadline = {1'b0, entry_ff.stamp} + (STAMP_W + 1)'(LIFE_MS);
   assign alive    = {1'b0, now_ms} <= deadline;
   assign match    = entry_ff.stamp == ref_stamp;
   assign entry    = entry_ff;

endmodule

`default_nettype wire

FILE: rtl/core/dpaf_fade.sv
// three-stage fade pipeline: window detect, byte*t product, divide by fade length
// depends on dpaf_pkg
`default_nettype none

module dpaf_fade (
   input  logic                          clock,
   input  logic                          reset,
   input  dpaf_pkg::fade_ctl_type        ctl,
   input  dpaf_pkg::entry_type           head,
   input  logic [dpaf_pkg::STAMP_W-1:0]  now_ms,
   output logic                          busy,
   output logic                          out_valid,
   output dpaf_pkg::result_type          result
);
   import dpaf_pkg::*;

   localparam int MUL_W = PROD_W + RECIP_W;
   localparam int NCH   = 4;
   localparam int CH_A  = 3;

   // window detect
   logic               fade_in;
   logic [T_W-1:0]     t_in;

   // stage 1
   logic               s1_valid_ff;
   entry_type          s1_entry_ff;
   logic               s1_last_ff;
   logic               s1_fade_rgb_ff;
   logic               s1_fade_a_ff;
   logic [T_W-1:0]     s1_t_ff;
   logic [COLOR_W-1:0] s1_ch [NCH];
   logic [COLOR_W-1:0] s1_mult [NCH];
   logic [NCH-1:0]     s2_scale_in;
   logic [PROD_W-1:0]  s2_prod_in [NCH];

   // stage 2
   logic                s2_valid_ff;
   logic [SHADER_W-1:0] s2_shader_ff;
   logic [VERTS_W-1:0]  s2_verts_ff;
   logic                s2_last_ff;
   logic [NCH-1:0]      s2_scale_ff;
   logic [PROD_W-1:0]   s2_prod_ff [NCH];
   logic [MUL_W-1:0]    s3_full [NCH];
   logic [COLOR_W-1:0]  s3_ch_in [NCH];

   // stage 3, the response register
   logic                out_valid_ff;
   result_type          result_ff;

   assign fade_in = ({1'b0, head.stamp} + (STAMP_W + 1)'(FADE_START_MS)) < {1'b0, now_ms};
   assign t_in    = head.stamp[T_W-1:0] - now_ms[T_W-1:0] + T_OFFSET;

   assign s1_ch[0] = s1_entry_ff.red;
   assign s1_ch[1] = s1_entry_ff.green;
   assign s1_ch[2] = s1_entry_ff.blue;
   assign s1_ch[3] = s1_entry_ff.alpha;

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         if (c == CH_A) begin
            s2_scale_in[c] = s1_fade_a_ff;
            s1_mult[c]     = s1_fade_a_ff ? COLOR_W'(COLOR_MAX) : s1_ch[c];
         end else begin
            s2_scale_in[c] = s1_fade_rgb_ff;
            s1_mult[c]     = s1_ch[c];
         end
         s2_prod_in[c] = s2_scale_in[c] ? PROD_W'(s1_mult[c]) * PROD_W'(s1_t_ff)
                                        : PROD_W'(s1_mult[c]);
      end
   end

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         s3_full[c]  = MUL_W'(s2_prod_ff[c]) * MUL_W'(DIV_RECIP);
         s3_ch_in[c] = s2_scale_ff[c] ? s3_full[c][DIV_SHIFT +: COLOR_W]
                                      : s2_prod_ff[c][COLOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         s1_valid_ff  <= ctl.valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         s1_entry_ff    <= head;
         s1_last_ff     <= ctl.last;
         s1_fade_rgb_ff <= fade_in && !head.fade_alpha_only;
         s1_fade_a_ff   <= fade_in && head.fade_alpha_only;
         s1_t_ff        <= t_in;

         s2_shader_ff <= s1_entry_ff.shader;
         s2_verts_ff  <= s1_entry_ff.verts;
         s2_last_ff   <= s1_last_ff;
         s2_scale_ff  <= s2_scale_in;
         for (int c = 0; c < NCH; c++) begin
            s2_prod_ff[c] <= s2_prod_in[c];
         end

         result_ff.shader <= s2_shader_ff;
         result_ff.verts  <= s2_verts_ff;
         result_ff.red    <= s3_ch_in[0];
         result_ff.green  <= s3_ch_in[1];
         result_ff.blue   <= s3_ch_in[2];
         result_ff.alpha  <= s3_ch_in[3];
         result_ff.last   <= s2_last_ff;
      end
   end

   assign busy      = s1_valid_ff || s2_valid_ff;
   assign out_valid = out_valid_ff;
   assign result    = result_ff;

endmodule

`default_nettype wire

FILE: rtl/core/dpaf_checker.sv
// port-level checks of the decal pool, attached to the top level by bind
// depends on dpaf_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module dpaf_checker #(
   parameter int MaxVerts = dpaf_pkg::MAX_VERTS
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [dpaf_pkg::SHADER_W-1:0]  rsp_shader,
   input logic [dpaf_pkg::VERTS_W-1:0]   rsp_verts,
   input logic [dpaf_pkg::COLOR_W-1:0]   rsp_red,
   input logic [dpaf_pkg::COLOR_W-1:0]   rsp_green,
   input logic [dpaf_pkg::COLOR_W-1:0]   rsp_blue,
   input logic [dpaf_pkg::COLOR_W-1:0]   rsp_alpha,
   input logic                           rsp_last
);
   import dpaf_pkg::*;

   localparam int PAYLOAD_W = SHADER_W + VERTS_W + 4 * COLOR_W + 1;

   logic                 rsp_stall;
   logic [PAYLOAD_W-1:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_shader, rsp_verts, rsp_red, rsp_green, rsp_blue, rsp_alpha,
                         rsp_last};

   // a stalled response keeps its transaction
   `DPAF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // no response comes out of reset
   `DPAF_ASSERT_NXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)

   // a pass that still owes results takes no new request
   `DPAF_ASSERT_IMP(a_busy_pass, clock, reset, rsp_valid && !rsp_last, !req_ready)

   // stored vertex counts are saturated
   `DPAF_ASSERT_IMP(a_verts_sat, clock, reset, rsp_valid, rsp_verts <= VERTS_W'(MaxVerts))

   // a request is taken only once the pass has shown its last result
   `DPAF_ASSERT_IMP(a_req_idle, clock, reset, req_valid && req_ready && rsp_valid, rsp_last)

endmodule

bind decal_pool_age_fade dpaf_checker #(
   .MaxVerts (MaxVerts)
) u_dpaf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_shader (rsp_bus.out_shader),
   .rsp_verts  (rsp_bus.out_verts),
   .rsp_red    (rsp_bus.mod_red),
   .rsp_green  (rsp_bus.mod_green),
   .rsp_blue   (rsp_bus.mod_blue),
   .rsp_alpha  (rsp_bus.mod_alpha),
   .rsp_last   (rsp_bus.last)
);

`default_nettype wire

FILE: tb/sv/tb_decal_pool_age_fade.sv
`timescale 1ns / 1ps
// self-checking testbench for decal_pool_age_fade: aged pool, eviction runs, fade and enable
// depends on dpaf_pkg, dpaf_if and the decal_pool_age_fade rtl

module tb_decal_pool_age_fade;
   import dpaf_pkg::*;

   localparam int      HALF_NS       = 4;
   localparam int      SETTLE_CYCLES = 160;         // full-pool eviction or 64-entry walk
   localparam int      HOLD_CYCLES   = 400;         // long receiver stall for the pressure test
   localparam longint  TIMEOUT_NS    = 20_000_000;

   // one request transaction as the sender sees it
   typedef struct packed {
      logic                cmd;
      logic [STAMP_W-1:0]  now_ms;
      logic [SHADER_W-1:0] shader_handle;
      logic [VERTS_W-1:0]  vert_count;
      logic [COLOR_W-1:0]  red;
      logic [COLOR_W-1:0]  green;
      logic [COLOR_W-1:0]  blue;
      logic [COLOR_W-1:0]  alpha;
      logic                fade_alpha_only;
   } mark_cmd_type;

   logic clock = 1'b0;
   logic reset;

   dpaf_req_if req_bus ();
   dpaf_rsp_if rsp_bus ();
   dpaf_csr_if csr_bus ();

   decal_pool_age_fade DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // clock: high phase then low phase
   always begin
      #(HALF_NS) clock = 1'b1;
      #(HALF_NS) clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // shadow of the block: live marks oldest first, the enable bit, and the render results
   // still owed by the block, oldest first
   // ---------------------------------------------------------------------------------------
   entry_type   live_marks[$];
   result_type  due_marks[$];
   logic        marks_on = 1'b1;
   logic [31:0] game_ms  = '0;

   int unsigned send_idle_pct    = 0;
   int unsigned recv_idle_pct    = 0;
   int unsigned recv_hold_cycles = 0;

   int unsigned fail_count      = 0;
   int unsigned items_accepted  = 0;
   int unsigned results_checked = 0;
   int unsigned renders_seen    = 0;
   int unsigned evicted_count   = 0;
   int unsigned expired_count   = 0;
   int unsigned faded_count     = 0;

   // first ten failures are printed, the rest only counted
   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endfunction

   // allocate: on a full pool drop the whole run of the oldest stamp, then append
   function automatic void store_model(input mark_cmd_type m);
      entry_type          e;
      logic [STAMP_W-1:0] run_stamp;
      if (live_marks.size() >= POOL_DEPTH) begin
         run_stamp = live_marks[0].stamp;
         while (live_marks.size() > 0 && live_marks[0].stamp == run_stamp) begin
            live_marks.delete(0);
            evicted_count++;
         end
      end
      e.stamp           = m.now_ms;
      e.shader          = m.shader_handle;
      e.red             = m.red;
      e.green           = m.green;
      e.blue            = m.blue;
      e.alpha           = m.alpha;
      e.fade_alpha_only = m.fade_alpha_only;
      e.verts           = (m.vert_count > MAX_VERTS) ? VERTS_W'(MAX_VERTS) : m.vert_count;
      live_marks.push_back(e);
   endfunction

   // render: newest to oldest, expired marks freed, survivors faded in their last second
   function automatic void render_model(input logic [STAMP_W-1:0] now);
      entry_type       survivors[$];
      result_type      shown[$];
      result_type      r;
      longint unsigned deadline;
      longint unsigned remain;
      int              k;
      renders_seen++;
      for (k = live_marks.size() - 1; k >= 0; k--) begin
         // deadline kept in 64 bits so stamps near the top do not wrap
         deadline = live_marks[k].stamp;
         deadline += LIFE_MS;
         if (now > deadline) begin
            expired_count++;
         end else begin
            remain  = deadline - now;
            r.shader = live_marks[k].shader;
            r.verts  = live_marks[k].verts;
            r.red    = live_marks[k].red;
            r.green  = live_marks[k].green;
            r.blue   = live_marks[k].blue;
            r.alpha  = live_marks[k].alpha;
            r.last   = 1'b0;
            if (remain < FADE_MS) begin
               faded_count++;
               if (live_marks[k].fade_alpha_only) begin
                  r.alpha = COLOR_W'(COLOR_MAX * remain / FADE_MS);
               end else begin
                  r.red   = COLOR_W'(live_marks[k].red * remain / FADE_MS);
                  r.green = COLOR_W'(live_marks[k].green * remain / FADE_MS);
                  r.blue  = COLOR_W'(live_marks[k].blue * remain / FADE_MS);
               end
            end
            shown.push_back(r);
            survivors.push_front(live_marks[k]);
         end
      end
      if (shown.size() > 0) begin
         r = shown.pop_back();
         r.last = 1'b1;
         shown.push_back(r);
      end
      live_marks = survivors;
      foreach (shown[i]) due_marks.push_back(shown[i]);
   endfunction

   function automatic void advance_pool(input mark_cmd_type m);
      if (marks_on) begin
         if (m.cmd == CMD_ALLOC) store_model(m);
         else render_model(m.now_ms);
      end
   endfunction

   // game clock moves forward only, saturating at the top of the stamp range
   function automatic void bump_game(input longint unsigned step);
      longint unsigned t;
      t = game_ms + step;
      game_ms = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
   endfunction

   function automatic mark_cmd_type mark_of(input logic [31:0] stamp, input logic [15:0] shader,
                                            input logic [3:0] verts, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic [7:0] a, input logic fade);
      mark_cmd_type m;
      m.cmd             = CMD_ALLOC;
      m.now_ms          = stamp;
      m.shader_handle   = shader;
      m.vert_count      = verts;
      m.red             = r;
      m.green           = g;
      m.blue            = b;
      m.alpha           = a;
      m.fade_alpha_only = fade;
      return m;
   endfunction

   function automatic mark_cmd_type random_mark(input logic [31:0] stamp);
      return mark_of(stamp, 16'($urandom), 4'($urandom_range(0, 15)), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
   endfunction

   // render transaction; the unused payload still carries random bits
   function automatic mark_cmd_type render_at(input logic [31:0] stamp);
      mark_cmd_type m;
      m     = random_mark(stamp);
      m.cmd = CMD_RENDER;
      return m;
   endfunction

   // ---------------------------------------------------------------------------------------
   // request side: called at a falling edge, returns at the falling edge after acceptance
   // with valid still high; the next call or drop_req_valid decides what follows
   // ---------------------------------------------------------------------------------------
   task automatic send_item(input mark_cmd_type m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.cmd             <= m.cmd;
      req_bus.now_ms          <= m.now_ms;
      req_bus.shader_handle   <= m.shader_handle;
      req_bus.vert_count      <= m.vert_count;
      req_bus.red             <= m.red;
      req_bus.green           <= m.green;
      req_bus.blue            <= m.blue;
      req_bus.alpha           <= m.alpha;
      req_bus.fade_alpha_only <= m.fade_alpha_only;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_accepted++;
      advance_pool(m);
      @(negedge clock);
   endtask

   task automatic drop_req_valid();
      req_bus.valid <= 1'b0;
   endtask

   // wait until every owed result is out, then let any eviction or empty walk finish
   task automatic settle_block();
      drop_req_valid();
      while (due_marks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_marks_enable(input logic value);
      settle_block();
      csr_bus.valid        <= 1'b1;
      csr_bus.marks_enable <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      marks_on = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // response side: ready is redrawn every falling edge unless a long hold is running
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (recv_hold_cycles > 0) begin
         rsp_bus.ready    <= 1'b0;
         recv_hold_cycles <= recv_hold_cycles - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // every accepted result is checked against the oldest owed one
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_marks.size() == 0) begin
            note_failure($sformatf("unexpected result shader %h verts %0d last %b",
                                   rsp_bus.out_shader, rsp_bus.out_verts, rsp_bus.last));
         end else begin
            want = due_marks.pop_front();
            results_checked++;
            if (rsp_bus.out_shader !== want.shader || rsp_bus.out_verts !== want.verts ||
                rsp_bus.mod_red !== want.red || rsp_bus.mod_green !== want.green ||
                rsp_bus.mod_blue !== want.blue || rsp_bus.mod_alpha !== want.alpha ||
                rsp_bus.last !== want.last) begin
               note_failure($sformatf(
                  {"exp shd %h v %0d rgba %h %h %h %h last %b, ",
                   "got shd %h v %0d rgba %h %h %h %h last %b"},
                  want.shader, want.verts, want.red, want.green, want.blue, want.alpha, want.last,
                  rsp_bus.out_shader, rsp_bus.out_verts, rsp_bus.mod_red, rsp_bus.mod_green,
                  rsp_bus.mod_blue, rsp_bus.mod_alpha, rsp_bus.last));
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // empty render, field extremes, vertex saturation, fade edges at 1000, 999, 0 and expiry
   task automatic test_fade_extremes();
      send_item(render_at(32'd0));
      send_item(mark_of(32'd0, 16'h0000, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
      send_item(mark_of(32'd0, 16'hFFFF, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_item(mark_of(32'd0, 16'hA5C3, 4'd10, 8'h12, 8'h80, 8'hFF, 8'h7F, 1'b0));
      send_item(mark_of(32'd0, 16'h5A3C, 4'd11, 8'hFF, 8'hC8, 8'h01, 8'hFF, 1'b1));
      send_item(render_at(32'd0));
      send_item(render_at(32'd9000));       // one full second left: no fade yet
      send_item(render_at(32'd9001));       // first faded step
      send_item(render_at(32'd9500));
      send_item(render_at(32'd10000));      // zero left, still alive
      send_item(render_at(32'd10001));      // everything expires
      send_item(render_at(32'd10001));      // and stays gone
   endtask

   // marks newer than now, a hole in the middle of the age order, stamps at the top
   task automatic test_time_reversal();
      send_item(mark_of(32'd20000, 16'h1111, 4'd4, 8'h40, 8'h80, 8'hC0, 8'hF0, 1'b1));
      send_item(mark_of(32'd5000, 16'h2222, 4'd5, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0));
      send_item(mark_of(32'd20000, 16'h3333, 4'd6, 8'hFE, 8'h7F, 8'h01, 8'hA0, 1'b0));
      send_item(mark_of(32'd30000, 16'h4444, 4'd3, 8'h99, 8'h66, 8'h33, 8'hCC, 1'b1));
      send_item(render_at(32'd16000));      // middle mark freed, newest shown in full
      send_item(render_at(32'd29500));      // both 20000 marks inside the fade
      send_item(random_mark(32'hFFFF_FF00));
      send_item(random_mark(32'hFFFF_FFFF));
      send_item(render_at(32'hFFFF_FFFF));  // deadline past 2^32 must not wrap
   endtask

   // full pool: single-mark runs, a long run, then the whole pool at once
   task automatic test_eviction_runs();
      while (live_marks.size() < POOL_DEPTH) send_item(random_mark(32'd50));
      repeat (3) send_item(random_mark(32'd60));
      send_item(render_at(32'd5000));
      send_item(render_at(32'd20000));      // clears the pool
      repeat (POOL_DEPTH + 1) send_item(random_mark(32'd20000));
      send_item(render_at(32'd20000));
   endtask

   // disabled: traffic is ignored and the pool is left as it was
   task automatic test_enable_register(input int unsigned n_ignored);
      write_marks_enable(1'b0);
      repeat (n_ignored) begin
         if ($urandom_range(1)) send_item(random_mark(game_ms));
         else send_item(render_at(game_ms));
      end
      write_marks_enable(1'b1);
      send_item(render_at(game_ms));
   endtask

   // long receiver stall while full-pool renders keep coming
   task automatic test_backpressure();
      game_ms = 32'd21000;
      while (live_marks.size() < POOL_DEPTH) send_item(random_mark(game_ms));
      drop_req_valid();
      @(posedge clock);
      recv_hold_cycles = HOLD_CYCLES;
      @(negedge clock);
      repeat (3) begin
         send_item(render_at(game_ms));
         send_item(random_mark(game_ms));
      end
   endtask

   // mostly allocation bursts and renders aimed at the fade window, some out-of-order noise
   task automatic test_random_traffic(input int unsigned n_items, input logic [31:0] base_ms);
      int unsigned     sent;
      int unsigned     pick;
      int unsigned     burst;
      int unsigned     idx;
      longint unsigned aim;
      logic [31:0]     stamp;
      if (base_ms > game_ms) game_ms = base_ms;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // burst with small steps and repeated stamps, fills the pool
            burst = $urandom_range(3, 40);
            repeat (burst) begin
               bump_game(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 25));
               send_item(random_mark(game_ms));
            end
            sent += burst;
         end else if (pick < 50) begin
            bump_game($urandom_range(100, 4000));
            send_item(random_mark(game_ms));
            sent++;
         end else if (pick < 88) begin
            if (live_marks.size() > 0 && $urandom_range(1)) begin
               // land somewhere around the last second of a random live mark
               idx = $urandom_range(live_marks.size() - 1);
               aim = live_marks[idx].stamp;
               aim += FADE_START_MS + $urandom_range(0, 1100);
               if (aim > game_ms) bump_game(aim - game_ms);
            end else begin
               bump_game($urandom_range(0, 600));
            end
            send_item(render_at(game_ms));
            sent++;
         end else begin
            // stamp anywhere or behind the game clock
            stamp = $urandom_range(1) ? 32'($urandom) : game_ms - $urandom_range(0, 12000);
            if ($urandom_range(1)) send_item(random_mark(stamp));
            else send_item(render_at(stamp));
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // run sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      // every input known from time zero
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.cmd             = CMD_ALLOC;
      req_bus.now_ms          = '0;
      req_bus.shader_handle   = '0;
      req_bus.vert_count      = '0;
      req_bus.red             = '0;
      req_bus.green           = '0;
      req_bus.blue            = '0;
      req_bus.alpha           = '0;
      req_bus.fade_alpha_only = 1'b0;
      rsp_bus.ready           = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.marks_enable    = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender mostly busy, receiver stalls about half the time
      send_idle_pct = 9;
      recv_idle_pct = 52;
      test_fade_extremes();
      test_time_reversal();
      test_eviction_runs();
      test_enable_register(4);
      test_backpressure();
      test_random_traffic(65, 32'd30000);

      // roles swapped, with a disabled stretch at the boundary
      send_idle_pct = 52;
      recv_idle_pct = 9;
      test_enable_register(8);
      test_random_traffic(65, 32'h8000_0000 + $urandom_range(0, 32'h00FF_FFFF));

      // back to back, stamps running into the top of the range
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(65, 32'hFFFF_8000);

      settle_block();
      $display("covered %0d transactions in, %0d results checked over %0d render passes",
               items_accepted, results_checked, renders_seen);
      $display("pool saw %0d evictions, %0d expiries, %0d faded results, %0d failures",
               evicted_count, expired_count, faded_count, fail_count);
      if (fail_count == 0) begin
         $display("PASS decal_pool_age_fade");
      end else begin
         $display("FAIL decal_pool_age_fade");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("FAIL decal_pool_age_fade");
      $finish;
   end

endmodule
